/* rtl/rlsp_pkg.sv */
// Shared types and constants for the recency list next slot picker.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package rlsp_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CFG_W           = 5;
  localparam int ID_W            = 32;
  localparam int LSLOT_W         = 4;
  localparam int SLOT_OUT_W      = 5;

  localparam logic [CFG_W-1:0] NUM_AVAIL_RST = 5'd1;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TOUCH = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COMPACT,
    ST_APPEND,
    ST_SCAN,
    ST_DECIDE,
    ST_FREE,
    ST_QRD,
    ST_QWAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [LSLOT_W-1:0] load_slot;
    logic [ID_W-1:0]    card_id;
  } in_req_t;

  typedef struct packed {
    logic [ID_W-1:0]       chosen_card_id;
    logic [SLOT_OUT_W-1:0] chosen_slot;
    logic                  reused_oldest;
    logic                  id_found;
  } out_res_t;

endpackage

`default_nettype wire

/* rtl/rlsp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the id table and the recency list; no package dependency.
`default_nettype none

module rlsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/recency_list_next_slot_picker.sv */
// A load goes straight to the finish state; a touch looks its id up in the first n id table
// entries, then compacts the recency list of length L, and a query scans that list, then the
// marks; n is the effective num_available, and each scan reads one entry per cycle.
// One request is in work at a time; in_stall is high from acceptance until the
// result is loaded into the output register, and a result still stalled holds the next back.
// Synchronous active-low reset empties the list and sets num_available to 1; the id table RAM
// is not cleared.
// Top level: sequencer plus two rlsp_ram instances; uses rlsp_pkg.
`default_nettype none

module recency_list_next_slot_picker #(
  parameter int MAX_ENTRIES = rlsp_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rlsp_pkg::in_req_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rlsp_pkg::out_res_t               out_data,
  input  wire logic                        cfg_we,
  input  wire logic [rlsp_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int SW     = $clog2(MAX_ENTRIES);
  localparam int LDEPTH = MAX_ENTRIES + 1;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int LW     = $clog2(MAX_ENTRIES + 1);
  localparam int CNTW   = $clog2(MAX_ENTRIES + 2);

  rlsp_pkg::state_t state_r, state_nxt;
  logic [rlsp_pkg::CFG_W-1:0] cfg_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            tag_vld_r, tag_vld_nxt;
  logic [CNTW-1:0] tag_r, tag_nxt;
  logic [CNTW-1:0] len_r, len_nxt;
  logic [CNTW-1:0] wptr_r, wptr_nxt;
  logic [CNTW-1:0] n_r, n_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [rlsp_pkg::ID_W-1:0] id_r, id_nxt;
  logic [rlsp_pkg::ID_W-1:0] cid_r, cid_nxt;
  logic [LW-1:0]   slot_r, slot_nxt;
  logic [LW-1:0]   oldest_r, oldest_nxt;
  logic            found_r, found_nxt;
  logic            reused_r, reused_nxt;
  logic [MAX_ENTRIES-1:0] listed_r, listed_nxt;
  logic            out_valid_r, out_valid_nxt;
  rlsp_pkg::out_res_t out_data_r, out_data_nxt;

  logic [CNTW-1:0] n_eff;
  logic            accept;
  logic            issue;

  logic                      tab_we;
  logic [SW-1:0]             tab_waddr;
  logic [SW-1:0]             tab_raddr;
  logic [rlsp_pkg::ID_W-1:0] tab_rdata;
  logic                      lst_we;
  logic [LAW-1:0]            lst_waddr;
  logic [LW-1:0]             lst_wdata;
  logic [LAW-1:0]            lst_raddr;
  logic [LW-1:0]             lst_rdata;

  rlsp_ram #(
    .WIDTH (rlsp_pkg::ID_W),
    .DEPTH (MAX_ENTRIES)
  ) u_id_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (in_data.card_id),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  rlsp_ram #(
    .WIDTH (LW),
    .DEPTH (LDEPTH)
  ) u_recency_list (
    .clk   (clk),
    .we    (lst_we),
    .waddr (lst_waddr),
    .wdata (lst_wdata),
    .raddr (lst_raddr),
    .rdata (lst_rdata)
  );

  // The register value is saturated into 1..MAX_ENTRIES when it is used.
  always_comb begin
    if (cfg_r == '0) begin
      n_eff = CNTW'(1);
    end else if (32'(cfg_r) > 32'(MAX_ENTRIES)) begin
      n_eff = CNTW'(MAX_ENTRIES);
    end else begin
      n_eff = CNTW'(cfg_r);
    end
  end

  assign in_stall  = (state_r != rlsp_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlsp_pkg::ST_IDLE;
      cfg_r       <= rlsp_pkg::NUM_AVAIL_RST;
      len_r       <= '0;
      tag_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      tag_vld_r   <= tag_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    tag_r      <= tag_nxt;
    wptr_r     <= wptr_nxt;
    n_r        <= n_nxt;
    count_r    <= count_nxt;
    id_r       <= id_nxt;
    cid_r      <= cid_nxt;
    slot_r     <= slot_nxt;
    oldest_r   <= oldest_nxt;
    found_r    <= found_nxt;
    reused_r   <= reused_nxt;
    listed_r   <= listed_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tag_vld_nxt   = 1'b0;
    tag_nxt       = cnt_r;
    len_nxt       = len_r;
    wptr_nxt      = wptr_r;
    n_nxt         = n_r;
    count_nxt     = count_r;
    id_nxt        = id_r;
    cid_nxt       = cid_r;
    slot_nxt      = slot_r;
    oldest_nxt    = oldest_r;
    found_nxt     = found_r;
    reused_nxt    = reused_r;
    listed_nxt    = listed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    issue         = 1'b0;
    tab_we        = 1'b0;
    tab_waddr     = SW'(in_data.load_slot);
    tab_raddr     = cnt_r[SW-1:0];
    lst_we        = 1'b0;
    lst_waddr     = wptr_r[LAW-1:0];
    lst_wdata     = lst_rdata;
    lst_raddr     = cnt_r[LAW-1:0];

    case (state_r)
      rlsp_pkg::ST_IDLE: begin
        if (accept) begin
          id_nxt     = in_data.card_id;
          n_nxt      = n_eff;
          cid_nxt    = '0;
          slot_nxt   = '0;
          found_nxt  = 1'b0;
          reused_nxt = 1'b0;
          cnt_nxt    = '0;
          case (in_data.req_type)
            rlsp_pkg::REQ_LOAD: begin
              tab_we    = (32'(in_data.load_slot) < 32'(MAX_ENTRIES));
              state_nxt = rlsp_pkg::ST_FINISH;
            end
            rlsp_pkg::REQ_TOUCH: begin
              state_nxt = rlsp_pkg::ST_LOOK;
            end
            rlsp_pkg::REQ_QUERY: begin
              listed_nxt = '0;
              count_nxt  = '0;
              oldest_nxt = '0;
              state_nxt  = rlsp_pkg::ST_SCAN;
            end
            default: begin
              state_nxt = rlsp_pkg::ST_FINISH;
            end
          endcase
        end
      end

      // Id lookup: one table read issued per cycle, compared when it returns.
      rlsp_pkg::ST_LOOK: begin
        issue       = (cnt_r < n_r);
        tag_vld_nxt = issue;
        if (issue) begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
        if (tag_vld_r && (tab_rdata == id_r)) begin
          slot_nxt    = LW'(tag_r);
          found_nxt   = 1'b1;
          cnt_nxt     = '0;
          tag_vld_nxt = 1'b0;
          wptr_nxt    = '0;
          state_nxt   = rlsp_pkg::ST_COMPACT;
        end else if (!tag_vld_r && !issue) begin
          slot_nxt  = LW'(n_r);
          cnt_nxt   = '0;
          wptr_nxt  = '0;
          state_nxt = rlsp_pkg::ST_COMPACT;
        end
      end

      // Copy the list onto itself without the touched slot. The write pointer never
      // passes the read pointer, so no entry is overwritten before it is read.
      rlsp_pkg::ST_COMPACT: begin
        issue       = (cnt_r < len_r);
        tag_vld_nxt = issue;
        if (issue) begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
        if (tag_vld_r && (lst_rdata != slot_r)) begin
          lst_we   = 1'b1;
          wptr_nxt = wptr_r + CNTW'(1);
        end
        if (!tag_vld_r && !issue) begin
          state_nxt = rlsp_pkg::ST_APPEND;
        end
      end

      rlsp_pkg::ST_APPEND: begin
        if (wptr_r < CNTW'(LDEPTH)) begin
          lst_we    = 1'b1;
          lst_wdata = slot_r;
          len_nxt   = wptr_r + CNTW'(1);
        end else begin
          len_nxt = wptr_r;
        end
        state_nxt = rlsp_pkg::ST_FINISH;
      end

      // Mark every listed slot below n and remember the oldest such entry.
      rlsp_pkg::ST_SCAN: begin
        issue       = (cnt_r < len_r);
        tag_vld_nxt = issue;
        if (issue) begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
        if (tag_vld_r && (CNTW'(lst_rdata) < n_r)) begin
          if (count_r == '0) begin
            oldest_nxt = lst_rdata;
          end
          if (!listed_r[lst_rdata[SW-1:0]]) begin
            listed_nxt[lst_rdata[SW-1:0]] = 1'b1;
            count_nxt = count_r + CNTW'(1);
          end
        end
        if (!tag_vld_r && !issue) begin
          state_nxt = rlsp_pkg::ST_DECIDE;
        end
      end

      rlsp_pkg::ST_DECIDE: begin
        if (count_r == n_r) begin
          slot_nxt   = oldest_r;
          reused_nxt = 1'b1;
          state_nxt  = rlsp_pkg::ST_QRD;
        end else begin
          cnt_nxt   = '0;
          state_nxt = rlsp_pkg::ST_FREE;
        end
      end

      // Walk the marks one slot per cycle up to the first free one.
      rlsp_pkg::ST_FREE: begin
        if ((cnt_r < n_r) && listed_r[cnt_r[SW-1:0]]) begin
          cnt_nxt = cnt_r + CNTW'(1);
        end else begin
          if (cnt_r >= n_r) begin
            slot_nxt = LW'(n_r - CNTW'(1));
          end else begin
            slot_nxt = LW'(cnt_r);
          end
          state_nxt = rlsp_pkg::ST_QRD;
        end
      end

      rlsp_pkg::ST_QRD: begin
        tab_raddr = slot_r[SW-1:0];
        state_nxt = rlsp_pkg::ST_QWAIT;
      end

      rlsp_pkg::ST_QWAIT: begin
        cid_nxt   = tab_rdata;
        state_nxt = rlsp_pkg::ST_FINISH;
      end

      rlsp_pkg::ST_FINISH: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.chosen_card_id = cid_r;
          out_data_nxt.chosen_slot    = rlsp_pkg::SLOT_OUT_W'(slot_r);
          out_data_nxt.reused_oldest  = reused_r;
          out_data_nxt.id_found       = found_r;
          state_nxt                   = rlsp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rlsp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rlsp_checker.sv */
// Port-level checker for the recency list next slot picker, bound to the top level.
// Uses rlsp_pkg for the payload types.
`default_nettype none

module rlsp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire rlsp_pkg::out_res_t         out_data
);

  // A stalled result must stay offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // Every accepted request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without going busy");

  // The block only becomes free again by delivering a result into the output register.
  a_free_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("block went idle without a result");

endmodule

bind recency_list_next_slot_picker rlsp_checker u_rlsp_checker (.*);

`default_nettype wire
